FILE: sv/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants of the keyed count table.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BITS    = 16;
  localparam int COUNT_BITS  = 32;
  localparam int TAG_BITS    = 16;
  localparam int STATUS_BITS = 3;

  localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_INVALID   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd5;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic                         action;
    logic [TAG_BITS-1:0]          tag_key;
    logic signed [COUNT_BITS-1:0] amount;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]       status;
    logic signed [COUNT_BITS-1:0] count_after;
    logic                         saturated;
  } rsp_item_t;

  // Signals handed from one cell to the next along the row.
  typedef struct packed {
    logic                  hit_seen;
    logic                  free_seen;
    logic [COUNT_BITS-1:0] count;
  } link_t;

  // Write command broadcast to all cells in the apply cycle.
  typedef struct packed {
    logic                  upd;
    logic                  ins;
    logic                  del;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } cmd_t;

endpackage

FILE: sv/keyed_count_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_count_table_unit
// Associative key-to-count table built as a row of entry cells.
//
// Each request item adds or removes a signed amount for a key; every item
// gives exactly one response item with a status, the count afterwards and a
// saturation flag. Key zero is rejected, a full table reports full instead of
// inserting, and sums are clamped to the signed 32-bit range. In the accept
// cycle the key is compared in every cell and the first-match and
// first-free flags ripple down the row and are stored in the cells; in the
// next cycle the selected count is collected from the row, the single
// add/clamp unit computes the new value, the response is registered and
// the write goes back to the selected cell. The next item is accepted in
// the cycle after that, so a new item is not taken before the last one is
// written back; a stalled response holds the block in the apply cycle.
// The table is empty after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module keyed_count_table_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  kct_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output kct_pkg::rsp_item_t rsp
);
  import kct_pkg::*;

  link_t               links [TABLE_DEPTH+1];
  logic                lookup;
  logic [KEY_BITS-1:0] lookup_key;
  cmd_t                cmd;

  // Head of the row: nothing seen yet, no count collected.
  assign links[0] = '0;

  // One cell per entry; each passes its match, free and count flags onward.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kct_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .lookup     (lookup),
      .lookup_key (lookup_key),
      .cmd        (cmd),
      .link_in    (links[i]),
      .link_out   (links[i+1])
    );
  end

  // Sequence the item, do the arithmetic and hold the response.
  kct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .lookup     (lookup),
    .lookup_key (lookup_key),
    .tail       (links[TABLE_DEPTH]),
    .cmd        (cmd)
  );

endmodule

FILE: sv/kct_cell.sv
// ----------------------------------------------------------------------------
// kct_cell
// One table entry: key compare, first-match and first-free chains, write back.
// ----------------------------------------------------------------------------
module kct_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         lookup,
  input  logic [kct_pkg::KEY_BITS-1:0] lookup_key,
  input  kct_pkg::cmd_t                cmd,
  input  kct_pkg::link_t               link_in,
  output kct_pkg::link_t               link_out
);
  import kct_pkg::*;

  logic                  valid;
  logic [KEY_BITS-1:0]   key;
  logic [COUNT_BITS-1:0] count;
  logic                  sel_hit;
  logic                  sel_free;
  logic                  match;

  assign match = valid && (key == lookup_key);

  always_comb begin
    link_out.hit_seen  = link_in.hit_seen | match;
    link_out.free_seen = link_in.free_seen | !valid;
    link_out.count     = link_in.count | (sel_hit ? count : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      sel_hit  <= 1'b0;
      sel_free <= 1'b0;
    end else begin
      if (lookup) begin
        sel_hit  <= match && !link_in.hit_seen;
        sel_free <= !valid && !link_in.free_seen;
      end
      if (sel_hit && cmd.del) begin
        valid <= 1'b0;
      end else if (sel_free && cmd.ins) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_hit && cmd.upd) begin
      count <= cmd.count;
    end else if (sel_hit && cmd.del) begin
      key   <= '0;
      count <= '0;
    end else if (sel_free && cmd.ins) begin
      key   <= cmd.key;
      count <= cmd.count;
    end
  end

endmodule

FILE: sv/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// Sequencer, count arithmetic with clamping, and the result register.
// ----------------------------------------------------------------------------
module kct_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  kct_pkg::req_item_t           req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output kct_pkg::rsp_item_t           rsp,
  output logic                         lookup,
  output logic [kct_pkg::KEY_BITS-1:0] lookup_key,
  input  kct_pkg::link_t               tail,
  output kct_pkg::cmd_t                cmd
);
  import kct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  state_t                state;
  state_t                state_next;
  logic                  act;
  logic [COUNT_BITS-1:0] amt;
  logic [KEY_BITS-1:0]   key;
  logic                  key_zero;
  logic                  any_hit;
  logic                  any_free;

  logic                  commit;
  logic [COUNT_BITS:0]   operand;
  logic [COUNT_BITS:0]   sum;
  logic                  ovf;
  logic [COUNT_BITS-1:0] clamped;
  logic                  not_positive;
  rsp_item_t             res;
  logic                  upd;
  logic                  ins;
  logic                  del;

  assign req_ready  = (state == S_IDLE);
  assign lookup     = req_valid && req_ready;
  assign lookup_key = req.tag_key[KEY_BITS-1:0];
  assign commit     = (state == S_APPLY) && (!rsp_valid || rsp_ready);

  // Remove runs as an add of the negated amount; the extra bit holds -MIN.
  always_comb begin
    operand = {amt[COUNT_BITS-1], amt};
    if (act == ACT_REMOVE) begin
      operand = -{amt[COUNT_BITS-1], amt};
    end
    sum          = {tail.count[COUNT_BITS-1], tail.count} + operand;
    ovf          = sum[COUNT_BITS] != sum[COUNT_BITS-1];
    clamped      = ovf ? (sum[COUNT_BITS] ? CNT_MIN : CNT_MAX) : sum[COUNT_BITS-1:0];
    not_positive = sum[COUNT_BITS] || (sum == '0);
  end

  always_comb begin
    res.status      = ST_NOT_FOUND;
    res.count_after = '0;
    res.saturated   = 1'b0;
    upd             = 1'b0;
    ins             = 1'b0;
    del             = 1'b0;
    if (key_zero) begin
      res.status = ST_INVALID;
    end else if (act == ACT_ADD) begin
      if (any_hit) begin
        res.status      = ST_UPDATED;
        res.count_after = clamped;
        res.saturated   = ovf;
        upd             = 1'b1;
      end else if (any_free) begin
        res.status      = ST_INSERTED;
        res.count_after = amt;
        ins             = 1'b1;
      end else begin
        res.status = ST_FULL;
      end
    end else if (any_hit) begin
      if (not_positive) begin
        res.status = ST_REMOVED;
        del        = 1'b1;
      end else begin
        res.status      = ST_UPDATED;
        res.count_after = clamped;
        res.saturated   = ovf;
        upd             = 1'b1;
      end
    end
  end

  always_comb begin
    cmd.upd   = commit && upd;
    cmd.ins   = commit && ins;
    cmd.del   = commit && del;
    cmd.key   = key;
    cmd.count = res.count_after;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (lookup) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      act      <= req.action;
      amt      <= req.amount;
      key      <= lookup_key;
      key_zero <= (lookup_key == '0);
      any_hit  <= tail.hit_seen;
      any_free <= tail.free_seen;
    end
    if (commit) begin
      rsp <= res;
    end
  end

endmodule
